// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fbrot_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrot_pkg
// Types, register map and fixed field widths of the framebuffer pixel
// rotate/mirror address mapper.
// ----------------------------------------------------------------------------
package fbrot_pkg;

    // Fixed field widths of the pixel and result transfers
    localparam int PIX_W     = 13;
    localparam int OFS_W     = 12;
    localparam int DIMCFG_W  = 12;
    localparam int NAT_W     = 11;
    localparam int BIDX_W    = 19;
    localparam int MASK_W    = 8;
    localparam int BIT_SEL_W = 3;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Pixels per framebuffer byte, minus one, and the leftmost pixel's mask
    localparam logic [BIT_SEL_W-1:0] PIX_PER_BYTE_M1 = 3'd7;
    localparam logic [MASK_W-1:0]    BIT_MASK_MSB    = 8'h80;

    // Register reset values
    localparam logic [DIMCFG_W-1:0] PANEL_WIDTH_RST  = 12'd128;
    localparam logic [DIMCFG_W-1:0] PANEL_HEIGHT_RST = 12'd296;

    typedef enum logic [1:0] {
        ORI_0,
        ORI_90,
        ORI_180,
        ORI_270
    } orient_t;

    typedef enum logic [2:0] {
        REG_PANEL_WIDTH,
        REG_PANEL_HEIGHT,
        REG_ORIENTATION,
        REG_FLIP_HORIZONTAL,
        REG_FLIP_VERTICAL,
        REG_INVERT_PIXELS,
        REG_OFFSET_X,
        REG_OFFSET_Y
    } reg_idx_t;

    typedef struct packed {
        logic [DIMCFG_W-1:0]      panel_width;
        logic [DIMCFG_W-1:0]      panel_height;
        orient_t                  orientation;
        logic                     flip_horizontal;
        logic                     flip_vertical;
        logic                     invert_pixels;
        logic signed [OFS_W-1:0]  offset_x;
        logic signed [OFS_W-1:0]  offset_y;
    } cfg_t;

    // Saturate a configured panel dimension to the supported maximum
    function automatic int clamp_dim(input logic [DIMCFG_W-1:0] dim, input int max_dim);
        int d;
        d = int'(dim);
        return (d > max_dim) ? max_dim : d;
    endfunction

endpackage

// ===== src/framebuffer_pixel_rotate_map_core.sv =====
// ----------------------------------------------------------------------------
// framebuffer_pixel_rotate_map_core
// Maps user-space 1 bpp pixels to native framebuffer byte index, bit mask
// and stored value, with clipping, rotation, mirroring and inversion.
//
//   channel   direction  transfer when         payload
//   s_        in         s_valid && s_ready    pixel_x, pixel_y, pixel_bit
//   m_        out        m_valid && m_ready    written, native_x/y, byte_index,
//                                              bit_mask, pixel_value
//   APB       in         psel&penable&pwrite   eight config registers
//
// One pixel per clock sustained while m_ready is high. An accepted pixel
// passes the input register, mapped register and result register in turn.
// The coordinate mapper sits in the first stage, the row-times-stride
// multiply in the second. Each stage advances when the one after it is empty
// or moving, so a stalled m_ready fills up to three pixels before s_ready drops.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register reset values.
// ----------------------------------------------------------------------------
module framebuffer_pixel_rotate_map_core #(
    parameter int MAX_DIM = 2048
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fbrot_pkg::PIX_W-1:0]     s_pixel_x,
    input  logic signed [fbrot_pkg::PIX_W-1:0]     s_pixel_y,
    input  logic                                   s_pixel_bit,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_written,
    output logic [fbrot_pkg::NAT_W-1:0]            m_native_x,
    output logic [fbrot_pkg::NAT_W-1:0]            m_native_y,
    output logic [fbrot_pkg::BIDX_W-1:0]           m_byte_index,
    output logic [fbrot_pkg::MASK_W-1:0]           m_bit_mask,
    output logic                                   m_pixel_value,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fbrot_pkg::APB_AW-1:0]           paddr,
    input  logic [fbrot_pkg::APB_DW-1:0]           pwdata,
    output logic [fbrot_pkg::APB_DW-1:0]           prdata,
    output logic                                   pready
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CRD_W = $clog2(MAX_DIM);
    localparam int PRD_W = CRD_W + DIM_W;
    localparam int IDX_W = fbrot_pkg::BIDX_W + PRD_W;
    localparam int NXW_W = fbrot_pkg::NAT_W + CRD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fbrot_pkg::cfg_t     cfg_reg, cfg_next;
    fbrot_pkg::reg_idx_t reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = fbrot_pkg::reg_idx_t'(paddr[fbrot_pkg::APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                fbrot_pkg::REG_PANEL_WIDTH:
                    cfg_next.panel_width = pwdata[fbrot_pkg::DIMCFG_W-1:0];
                fbrot_pkg::REG_PANEL_HEIGHT:
                    cfg_next.panel_height = pwdata[fbrot_pkg::DIMCFG_W-1:0];
                fbrot_pkg::REG_ORIENTATION:
                    cfg_next.orientation = fbrot_pkg::orient_t'(pwdata[1:0]);
                fbrot_pkg::REG_FLIP_HORIZONTAL:
                    cfg_next.flip_horizontal = pwdata[0];
                fbrot_pkg::REG_FLIP_VERTICAL:
                    cfg_next.flip_vertical = pwdata[0];
                fbrot_pkg::REG_INVERT_PIXELS:
                    cfg_next.invert_pixels = pwdata[0];
                fbrot_pkg::REG_OFFSET_X:
                    cfg_next.offset_x = pwdata[fbrot_pkg::OFS_W-1:0];
                fbrot_pkg::REG_OFFSET_Y:
                    cfg_next.offset_y = pwdata[fbrot_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width     <= fbrot_pkg::PANEL_WIDTH_RST;
            cfg_reg.panel_height    <= fbrot_pkg::PANEL_HEIGHT_RST;
            cfg_reg.orientation     <= fbrot_pkg::ORI_0;
            cfg_reg.flip_horizontal <= 1'b0;
            cfg_reg.flip_vertical   <= 1'b0;
            cfg_reg.invert_pixels   <= 1'b0;
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            fbrot_pkg::REG_PANEL_WIDTH:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.panel_width);
            fbrot_pkg::REG_PANEL_HEIGHT:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.panel_height);
            fbrot_pkg::REG_ORIENTATION:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.orientation);
            fbrot_pkg::REG_FLIP_HORIZONTAL:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.flip_horizontal);
            fbrot_pkg::REG_FLIP_VERTICAL:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.flip_vertical);
            fbrot_pkg::REG_INVERT_PIXELS:
                prdata = fbrot_pkg::APB_DW'(cfg_reg.invert_pixels);
            fbrot_pkg::REG_OFFSET_X:
                prdata = fbrot_pkg::APB_DW'($unsigned(fbrot_pkg::APB_DW'(cfg_reg.offset_x)));
            fbrot_pkg::REG_OFFSET_Y:
                prdata = fbrot_pkg::APB_DW'($unsigned(fbrot_pkg::APB_DW'(cfg_reg.offset_y)));
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic in_vld_reg, map_vld_reg, out_vld_reg;
    logic in_en, map_en, out_en;

    assign out_en  = !out_vld_reg || m_ready;
    assign map_en  = !map_vld_reg || out_en;
    assign in_en   = !in_vld_reg || map_en;
    assign s_ready = in_en;
    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            map_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_en) begin
                in_vld_reg <= s_valid;
            end
            if (map_en) begin
                map_vld_reg <= in_vld_reg;
            end
            if (out_en) begin
                out_vld_reg <= map_vld_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: hold the accepted pixel
    // ------------------------------------------------------------------
    logic signed [fbrot_pkg::PIX_W-1:0] px_reg, py_reg;
    logic                               pbit_reg;

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            px_reg   <= s_pixel_x;
            py_reg   <= s_pixel_y;
            pbit_reg <= s_pixel_bit;
        end
    end

    // ------------------------------------------------------------------
    // Map stage: clip, rotate, mirror
    // ------------------------------------------------------------------
    logic             map_written;
    logic [CRD_W-1:0] map_nx, map_ny;

    fbrot_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map (
        .cfg     (cfg_reg),
        .pixel_x (px_reg),
        .pixel_y (py_reg),
        .written (map_written),
        .nat_x   (map_nx),
        .nat_y   (map_ny)
    );

    logic             wr_reg;
    logic [CRD_W-1:0] nx_reg, ny_reg;
    logic             val_reg;

    always_ff @(posedge aclk) begin
        if (map_en && in_vld_reg) begin
            wr_reg  <= map_written;
            nx_reg  <= map_nx;
            ny_reg  <= map_ny;
            val_reg <= pbit_reg ^ cfg_reg.invert_pixels;
        end
    end

    // ------------------------------------------------------------------
    // Address stage: row times stride plus column byte, bit mask
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W:0]   w_round;
    logic [DIM_W-1:0] stride;
    logic [PRD_W-1:0] row_base;
    logic [IDX_W-1:0] idx_wide;
    logic [NXW_W-1:0] nx_wide, ny_wide;

    logic                          res_written;
    logic [fbrot_pkg::NAT_W-1:0]   res_nx, res_ny;
    logic [fbrot_pkg::BIDX_W-1:0]  res_idx;
    logic [fbrot_pkg::MASK_W-1:0]  res_mask;
    logic                          res_val;

    always_comb begin
        dim_w    = DIM_W'(fbrot_pkg::clamp_dim(cfg_reg.panel_width, MAX_DIM));
        w_round  = (DIM_W + 1)'(dim_w) + (DIM_W + 1)'(fbrot_pkg::PIX_PER_BYTE_M1);
        stride   = DIM_W'(w_round >> fbrot_pkg::BIT_SEL_W);
        row_base = PRD_W'(ny_reg) * PRD_W'(stride);
        idx_wide = IDX_W'(row_base) + IDX_W'(nx_reg >> fbrot_pkg::BIT_SEL_W);
        nx_wide  = NXW_W'(nx_reg);
        ny_wide  = NXW_W'(ny_reg);

        // Drop every field of a clipped pixel
        res_written = wr_reg;
        if (wr_reg) begin
            res_nx   = nx_wide[fbrot_pkg::NAT_W-1:0];
            res_ny   = ny_wide[fbrot_pkg::NAT_W-1:0];
            res_idx  = idx_wide[fbrot_pkg::BIDX_W-1:0];
            res_mask = fbrot_pkg::BIT_MASK_MSB >> nx_reg[fbrot_pkg::BIT_SEL_W-1:0];
            res_val  = val_reg;
        end else begin
            res_nx   = '0;
            res_ny   = '0;
            res_idx  = '0;
            res_mask = '0;
            res_val  = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_en && map_vld_reg) begin
            m_written     <= res_written;
            m_native_x    <= res_nx;
            m_native_y    <= res_ny;
            m_byte_index  <= res_idx;
            m_bit_mask    <= res_mask;
            m_pixel_value <= res_val;
        end
    end

endmodule

// ===== src/fbrot_map.sv =====
// ----------------------------------------------------------------------------
// fbrot_map
// Coordinate mapper: applies the offsets, clips against the visible area
// and rotates and mirrors the point into native panel space.
// ----------------------------------------------------------------------------
module fbrot_map #(
    parameter int MAX_DIM = 2048
) (
    input  fbrot_pkg::cfg_t                         cfg,
    input  logic signed [fbrot_pkg::PIX_W-1:0]      pixel_x,
    input  logic signed [fbrot_pkg::PIX_W-1:0]      pixel_y,
    output logic                                    written,
    output logic [$clog2(MAX_DIM)-1:0]              nat_x,
    output logic [$clog2(MAX_DIM)-1:0]              nat_y
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CRD_W = $clog2(MAX_DIM);
    localparam int SUM_W = fbrot_pkg::PIX_W + 1;
    localparam int CW    = (DIM_W + 1 > SUM_W) ? DIM_W + 1 : SUM_W;
    localparam logic signed [CW-1:0] ONE = CW'(1);

    logic [DIM_W-1:0]     w, h;
    logic signed [CW-1:0] ux, uy, ws, hs, vws, vhs;
    logic signed [CW-1:0] rx0, ry0, rx1, ry1;
    logic                 land;

    always_comb begin
        // Saturate dimensions and shift the point by the offsets
        w   = DIM_W'(fbrot_pkg::clamp_dim(cfg.panel_width, MAX_DIM));
        h   = DIM_W'(fbrot_pkg::clamp_dim(cfg.panel_height, MAX_DIM));
        ws  = CW'(w);
        hs  = CW'(h);
        ux  = CW'(pixel_x) + CW'(cfg.offset_x);
        uy  = CW'(pixel_y) + CW'(cfg.offset_y);

        // Visible area swaps width and height in landscape orientations
        land = (cfg.orientation == fbrot_pkg::ORI_90) ||
               (cfg.orientation == fbrot_pkg::ORI_270);
        vws  = land ? hs : ws;
        vhs  = land ? ws : hs;

        written = !(ux[CW-1] || uy[CW-1] || (ux >= vws) || (uy >= vhs));

        // Rotate into native space
        case (cfg.orientation)
            fbrot_pkg::ORI_90: begin
                rx0 = ws - ONE - uy;
                ry0 = ux;
            end
            fbrot_pkg::ORI_180: begin
                rx0 = ws - ONE - ux;
                ry0 = hs - ONE - uy;
            end
            fbrot_pkg::ORI_270: begin
                rx0 = uy;
                ry0 = hs - ONE - ux;
            end
            default: begin
                rx0 = ux;
                ry0 = uy;
            end
        endcase

        // Mirror after rotation
        rx1 = cfg.flip_horizontal ? (ws - ONE - rx0) : rx0;
        ry1 = cfg.flip_vertical   ? (hs - ONE - ry0) : ry0;

        nat_x = CRD_W'(rx1);
        nat_y = CRD_W'(ry1);
    end

endmodule

// ===== src/fbrot_checker.sv =====
// ----------------------------------------------------------------------------
// fbrot_checker
// Port-level checks on the result channel of the pixel mapper, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbrot_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_written,
    input logic [fbrot_pkg::NAT_W-1:0]         m_native_x,
    input logic [fbrot_pkg::NAT_W-1:0]         m_native_y,
    input logic [fbrot_pkg::BIDX_W-1:0]        m_byte_index,
    input logic [fbrot_pkg::MASK_W-1:0]        m_bit_mask,
    input logic                                m_pixel_value,
    input logic                                pready
);

    logic res_stall, res_wr, res_clip, clip_zero, mask_col;

    // Conditions on the result channel
    assign res_stall = m_valid && !m_ready;
    assign res_wr    = m_valid && m_written;
    assign res_clip  = m_valid && !m_written;
    assign clip_zero = (m_native_x == '0) && (m_native_y == '0) && (m_byte_index == '0) &&
                       (m_bit_mask == '0) && !m_pixel_value;
    assign mask_col  = (m_native_x[2:0] == 3'd0) == m_bit_mask[7];

    // A stalled result transfer holds its address
    `ASSERT_NEXT(a_hold, aclk, aresetn, res_stall, m_valid && $stable(m_byte_index), "hold broken")

    // A clipped pixel carries all-zero fields
    `ASSERT_IMPL(a_clip_zero, aclk, aresetn, res_clip, clip_zero, "clipped pixel has nonzero fields")

    // A written pixel selects exactly one bit of its byte
    `ASSERT_IMPL(a_mask_onehot, aclk, aresetn, res_wr, $onehot(m_bit_mask), "bit mask not one-hot")

    // The leftmost mask bit goes with a column that is a multiple of eight
    `ASSERT_IMPL(a_mask_column, aclk, aresetn, res_wr, mask_col, "bit mask does not match column")

    // The register port never inserts wait states
    `ASSERT_ALWAYS(a_pready, aclk, aresetn, pready, "pready dropped")

endmodule

bind framebuffer_pixel_rotate_map_core fbrot_checker u_fbrot_checker (.*);

// ===== verif/framebuffer_pixel_rotate_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_rotate_map_checker
// Watches the pixel, result and register ports of the rotate/mirror mapper.
// It keeps its own copy of the registers from the observed APB writes and
// predicts each result when its pixel transfers in. It then compares every
// result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module framebuffer_pixel_rotate_map_checker #(
    parameter int MAX_DIM = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [fbrot_pkg::PIX_W-1:0]  s_pixel_x,
    input  logic signed [fbrot_pkg::PIX_W-1:0]  s_pixel_y,
    input  logic                                s_pixel_bit,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_written,
    input  logic [fbrot_pkg::NAT_W-1:0]         m_native_x,
    input  logic [fbrot_pkg::NAT_W-1:0]         m_native_y,
    input  logic [fbrot_pkg::BIDX_W-1:0]        m_byte_index,
    input  logic [fbrot_pkg::MASK_W-1:0]        m_bit_mask,
    input  logic                                m_pixel_value,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [fbrot_pkg::APB_AW-1:0]        paddr,
    input  logic [fbrot_pkg::APB_DW-1:0]        pwdata,

    output int                                  mismatches,
    output int                                  maps_pending
);

    typedef struct packed {
        logic                         written;
        logic [fbrot_pkg::NAT_W-1:0]  native_x;
        logic [fbrot_pkg::NAT_W-1:0]  native_y;
        logic [fbrot_pkg::BIDX_W-1:0] byte_index;
        logic [fbrot_pkg::MASK_W-1:0] bit_mask;
        logic                         pixel_value;
    } pixel_map_t;

    fbrot_pkg::cfg_t panel_cfg;
    pixel_map_t      expected_maps[$];
    int              errs = 0;

    // Clip, rotate, mirror and address one user-space pixel
    function automatic pixel_map_t map_pixel(input fbrot_pkg::cfg_t c,
                                             input logic signed [fbrot_pkg::PIX_W-1:0] px,
                                             input logic signed [fbrot_pkg::PIX_W-1:0] py,
                                             input logic pbit);
        pixel_map_t r;
        int w, h, ux, uy, vw, vh, rx, ry, addr;
        bit land;
        r = '0;
        w = (int'(c.panel_width) > MAX_DIM) ? MAX_DIM : int'(c.panel_width);
        h = (int'(c.panel_height) > MAX_DIM) ? MAX_DIM : int'(c.panel_height);
        ux = int'($signed(px)) + int'($signed(c.offset_x));
        uy = int'($signed(py)) + int'($signed(c.offset_y));
        land = (c.orientation == fbrot_pkg::ORI_90) || (c.orientation == fbrot_pkg::ORI_270);
        vw = land ? h : w;
        vh = land ? w : h;
        // drop pixels outside the visible area with an all-zero result
        if (ux < 0 || uy < 0 || ux >= vw || uy >= vh)
            return r;
        case (c.orientation)
            fbrot_pkg::ORI_90: begin
                rx = w - 1 - uy;
                ry = ux;
            end
            fbrot_pkg::ORI_180: begin
                rx = w - 1 - ux;
                ry = h - 1 - uy;
            end
            fbrot_pkg::ORI_270: begin
                rx = uy;
                ry = h - 1 - ux;
            end
            default: begin
                rx = ux;
                ry = uy;
            end
        endcase
        if (c.flip_horizontal)
            rx = w - 1 - rx;
        if (c.flip_vertical)
            ry = h - 1 - ry;
        // row times byte stride, plus the byte holding the column
        addr = ry * ((w + 7) >> 3) + (rx >> 3);
        r.written     = 1'b1;
        r.native_x    = rx[fbrot_pkg::NAT_W-1:0];
        r.native_y    = ry[fbrot_pkg::NAT_W-1:0];
        r.byte_index  = addr[fbrot_pkg::BIDX_W-1:0];
        r.bit_mask    = fbrot_pkg::BIT_MASK_MSB >> rx[fbrot_pkg::BIT_SEL_W-1:0];
        r.pixel_value = pbit ^ c.invert_pixels;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_map_t want;
        if (!aresetn) begin
            panel_cfg              = '0;
            panel_cfg.panel_width  = fbrot_pkg::PANEL_WIDTH_RST;
            panel_cfg.panel_height = fbrot_pkg::PANEL_HEIGHT_RST;
            panel_cfg.orientation  = fbrot_pkg::ORI_0;
            expected_maps.delete();
        end else begin
            // compare each result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_maps.size() == 0) begin
                    $error("result transfer with no pixel outstanding");
                    errs++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("written", want.written, m_written);
                    check_field("native_x", want.native_x, m_native_x);
                    check_field("native_y", want.native_y, m_native_y);
                    check_field("byte_index", want.byte_index, m_byte_index);
                    check_field("bit_mask", want.bit_mask, m_bit_mask);
                    check_field("pixel_value", want.pixel_value, m_pixel_value);
                end
            end
            // predict on each pixel transfer
            if (s_valid && s_ready)
                expected_maps.push_back(map_pixel(panel_cfg, s_pixel_x, s_pixel_y,
                                                  s_pixel_bit));
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (fbrot_pkg::reg_idx_t'(paddr[fbrot_pkg::APB_AW-1:2]))
                    fbrot_pkg::REG_PANEL_WIDTH:
                        panel_cfg.panel_width = pwdata[fbrot_pkg::DIMCFG_W-1:0];
                    fbrot_pkg::REG_PANEL_HEIGHT:
                        panel_cfg.panel_height = pwdata[fbrot_pkg::DIMCFG_W-1:0];
                    fbrot_pkg::REG_ORIENTATION:
                        panel_cfg.orientation = fbrot_pkg::orient_t'(pwdata[1:0]);
                    fbrot_pkg::REG_FLIP_HORIZONTAL:
                        panel_cfg.flip_horizontal = pwdata[0];
                    fbrot_pkg::REG_FLIP_VERTICAL:
                        panel_cfg.flip_vertical = pwdata[0];
                    fbrot_pkg::REG_INVERT_PIXELS:
                        panel_cfg.invert_pixels = pwdata[0];
                    fbrot_pkg::REG_OFFSET_X:
                        panel_cfg.offset_x = pwdata[fbrot_pkg::OFS_W-1:0];
                    fbrot_pkg::REG_OFFSET_Y:
                        panel_cfg.offset_y = pwdata[fbrot_pkg::OFS_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches   <= errs;
        maps_pending <= expected_maps.size();
    end

endmodule

// ===== verif/framebuffer_pixel_rotate_map_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_rotate_map_core_test
// Drives pixels through the rotate/mirror mapper under a series of register
// settings: a directed set of corner pixels first, then random pixels
// clustered around the visible edges plus full-range noise. Both channels
// stall at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module framebuffer_pixel_rotate_map_core_test;

    localparam int CLIP_DIM = 2048;

    logic                                aclk;
    logic                                aresetn = 1'b0;

    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [fbrot_pkg::PIX_W-1:0]  s_pixel_x = '0;
    logic signed [fbrot_pkg::PIX_W-1:0]  s_pixel_y = '0;
    logic                                s_pixel_bit = 1'b0;

    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic                                m_written;
    logic [fbrot_pkg::NAT_W-1:0]         m_native_x;
    logic [fbrot_pkg::NAT_W-1:0]         m_native_y;
    logic [fbrot_pkg::BIDX_W-1:0]        m_byte_index;
    logic [fbrot_pkg::MASK_W-1:0]        m_bit_mask;
    logic                                m_pixel_value;

    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [fbrot_pkg::APB_AW-1:0]        paddr = '0;
    logic [fbrot_pkg::APB_DW-1:0]        pwdata = '0;
    logic [fbrot_pkg::APB_DW-1:0]        prdata;
    logic                                pready;

    int                                  mismatches;
    int                                  maps_pending;

    // visible extents and offsets of the current setting, for shaping stimulus
    int                                  vis_w = 128;
    int                                  vis_h = 296;
    int                                  cur_ox = 0;
    int                                  cur_oy = 0;
    bit                                  calm = 1'b0;

    framebuffer_pixel_rotate_map_core #(
        .MAX_DIM (CLIP_DIM)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_bit   (s_pixel_bit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_written     (m_written),
        .m_native_x    (m_native_x),
        .m_native_y    (m_native_y),
        .m_byte_index  (m_byte_index),
        .m_bit_mask    (m_bit_mask),
        .m_pixel_value (m_pixel_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    framebuffer_pixel_rotate_map_checker #(
        .MAX_DIM (CLIP_DIM)
    ) map_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_bit   (s_pixel_bit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_written     (m_written),
        .m_native_x    (m_native_x),
        .m_native_y    (m_native_y),
        .m_byte_index  (m_byte_index),
        .m_bit_mask    (m_bit_mask),
        .m_pixel_value (m_pixel_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .maps_pending  (maps_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Coordinate near the visible range, edges favored
    function automatic int near_coord(input int span);
        case ($urandom_range(0, 7))
            0: return -1;
            1: return span;
            2: return 0;
            3: return span - 1;
            default: return int'($urandom_range(0, (span > 0) ? span - 1 : 0));
        endcase
    endfunction

    function automatic int draw_dim();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return 1;
                    2: return CLIP_DIM;
                    3: return CLIP_DIM + 1;
                    default: return 4095;
                endcase
            end
            1, 2, 3: return int'($urandom_range(1, 16));
            4, 5, 6: return int'($urandom_range(1, 300));
            default: return int'($urandom_range(1, CLIP_DIM));
        endcase
    endfunction

    function automatic int draw_offset();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: return -2048;
                1: return 2047;
                default: return 0;
            endcase
        end
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // Setup and access cycle of one register write
    task automatic write_reg(input fbrot_pkg::reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int w, input int h, input fbrot_pkg::orient_t ori,
                              input bit fh, input bit fv, input bit inv,
                              input int ox, input int oy);
        int wc, hc;
        bit land;
        write_reg(fbrot_pkg::REG_PANEL_WIDTH, w);
        write_reg(fbrot_pkg::REG_PANEL_HEIGHT, h);
        write_reg(fbrot_pkg::REG_ORIENTATION, ori);
        write_reg(fbrot_pkg::REG_FLIP_HORIZONTAL, fh);
        write_reg(fbrot_pkg::REG_FLIP_VERTICAL, fv);
        write_reg(fbrot_pkg::REG_INVERT_PIXELS, inv);
        write_reg(fbrot_pkg::REG_OFFSET_X, ox);
        write_reg(fbrot_pkg::REG_OFFSET_Y, oy);
        wc = (w > CLIP_DIM) ? CLIP_DIM : w;
        hc = (h > CLIP_DIM) ? CLIP_DIM : h;
        land   = (ori == fbrot_pkg::ORI_90 || ori == fbrot_pkg::ORI_270);
        vis_w  = land ? hc : wc;
        vis_h  = land ? wc : hc;
        cur_ox = ox;
        cur_oy = oy;
    endtask

    // Hold one pixel on the input channel until it transfers
    task automatic send_pixel(input int x, input int y, input bit b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_x   <= x[fbrot_pkg::PIX_W-1:0];
        s_pixel_y   <= y[fbrot_pkg::PIX_W-1:0];
        s_pixel_bit <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_pixel();
        int px, py;
        if ($urandom_range(0, 4) == 0) begin
            px = int'($urandom_range(0, 8191)) - 4096;
            py = int'($urandom_range(0, 8191)) - 4096;
        end else begin
            px = near_coord(vis_w) - cur_ox;
            py = near_coord(vis_h) - cur_oy;
            if (px < -4096 || px > 4095)
                px = int'($urandom_range(0, 8191)) - 4096;
            if (py < -4096 || py > 4095)
                py = int'($urandom_range(0, 8191)) - 4096;
        end
        send_pixel(px, py, $urandom_range(0, 1));
    endtask

    // Release the input and wait until every predicted result has come out
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (maps_pending != 0) @(posedge aclk);
    endtask

    // Result side: random stalls on m_ready
    task automatic accept_results();
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            accept_results();
        join_none

        // corners and clipping under the reset setting
        send_pixel(0, 0, 1);
        send_pixel(127, 295, 0);
        send_pixel(128, 0, 1);
        send_pixel(0, 296, 1);
        send_pixel(-1, 5, 1);
        send_pixel(5, -1, 0);
        send_pixel(-4096, -4096, 1);
        send_pixel(4095, 4095, 1);
        send_pixel(7, 1, 1);
        send_pixel(8, 1, 0);

        // 90 degrees, both mirrors, inversion, extreme offsets
        drain_pipeline();
        set_config(128, 296, fbrot_pkg::ORI_90, 1, 1, 1, -2048, 2047);
        send_pixel(2048, -2047, 0);
        send_pixel(2343, -1920, 1);
        send_pixel(2344, -2047, 1);

        drain_pipeline();
        set_config(128, 296, fbrot_pkg::ORI_180, 0, 0, 0, 0, 0);
        send_pixel(0, 0, 1);
        send_pixel(127, 295, 1);

        drain_pipeline();
        set_config(128, 296, fbrot_pkg::ORI_270, 0, 1, 0, 0, 0);
        send_pixel(0, 0, 0);
        send_pixel(295, 127, 1);

        // empty panel: nothing is visible
        drain_pipeline();
        set_config(0, 296, fbrot_pkg::ORI_0, 0, 0, 1, 0, 0);
        send_pixel(0, 0, 1);

        // oversized width saturates to the largest panel
        drain_pipeline();
        set_config(4095, CLIP_DIM, fbrot_pkg::ORI_0, 1, 1, 0, 0, 0);
        send_pixel(2047, 2047, 1);
        send_pixel(2048, 0, 1);
        send_pixel(0, 2048, 1);

        // random settings, each with a batch of random pixels
        for (int phase = 0; phase < 14; phase++) begin
            drain_pipeline();
            set_config(draw_dim(), draw_dim(), fbrot_pkg::orient_t'($urandom_range(0, 3)),
                       $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), draw_offset(), draw_offset());
            for (int n = 0; n < 86; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_random_pixel();
            end
        end

        drain_pipeline();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && maps_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/fbrot_pkg.sv
src/fbrot_map.sv
src/framebuffer_pixel_rotate_map_core.sv
src/fbrot_checker.sv
verif/framebuffer_pixel_rotate_map_checker.sv
verif/framebuffer_pixel_rotate_map_core_test.sv
